/* rtl/aes_block_cipher_top_defines.svh */
// Assertion macros shared by the AES block cipher checker.
// No dependencies.
`ifndef AES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define AES_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`endif

/* rtl/aes_pkg.sv */
// AES package: S-box tables, GF(2^8) helpers, sequencer state and register codes.
// No dependencies.
package aes_pkg;
  typedef enum logic [2:0] {
    CfgKey0 = 3'd0, CfgKey1 = 3'd1, CfgKey2 = 3'd2, CfgKey3 = 3'd3, CfgKeySize = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle, StExpand, StCopy, StInit, StRound, StOut
  } state_e;

  localparam logic CmdEnc = 1'b0;
  localparam logic CmdDec = 1'b1;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // inverse = forward mix of a column pre-conditioned by {04,00,05,00}
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [1:0] src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 2'(c + 4 - r) : 2'(c + r);
        t[127 - 8*(c*4+r) -: 8] = s[127 - 8*(int'(src)*4+r) -: 8];
      end
    end
    shift_rows = t;
  endfunction
endpackage

/* rtl/aes_if.sv */
// Valid/ready channel interfaces for AES items and configuration writes.
// Depends on nothing.
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, cmd, block_hi, block_lo, input ready);
  modport sink (input valid, cmd, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/aes_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module aes_ram #(
  parameter int Width = 64,
  parameter int Depth = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

/* rtl/aes_block_cipher_top.sv */
// AES-128/192/256 block cipher top level: the rounds run one after another over a shared round unit.
// An accepted item passes through StInit, StRound and StOut; the result is held in res_q until taken.
// One item at a time: a new item is taken only in StIdle, once the last result has been taken.
// The round-key RAM has one 64-bit port: each round reads its 128-bit key as two halves, high then low.
// After a key or key-size write the schedule is expanded, one word a cycle, 4*(Nr+1) words with copy.
// Reset clears control state; the schedule is expanded before the first item.
// Depends on aes_pkg, aes_if and aes_ram.
module aes_block_cipher_top (
  input  logic clk_i,
  input  logic rst_ni,
  aes_cfg_if.sink   cfg,
  aes_in_if.sink    in_ch,
  aes_out_if.source out_ch
);
  import aes_pkg::*;

  state_e       state_q, state_d;
  logic [63:0]  key_q [4];
  logic [1:0]   ksize_q;
  logic         sched_ok_q, sched_ok_d;
  logic [255:0] kw_q, kw_d;       // sliding window of last Nk words
  logic [5:0]   wi_q, wi_d;       // word index
  logic [2:0]   wmod_q, wmod_d;   // wi mod Nk
  logic [7:0]   rc_q, rc_d;
  logic [31:0]  wprev_q, wprev_d; // pending even word
  logic [4:0]   addr_q, addr_d;
  logic         phase_q, phase_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         dec_q, dec_d;
  logic [127:0] st_q, st_d;
  logic [63:0]  khi_q, khi_d;
  logic         ovalid_q, ovalid_d;
  logic [127:0] res_q, res_d;

  logic [3:0] nk;
  logic [3:0] nr;
  logic [5:0] total;
  always_comb begin
    unique case (ksize_q)
      2'd0:    begin nk = 4'd4; nr = 4'd10; end
      2'd1:    begin nk = 4'd6; nr = 4'd12; end
      default: begin nk = 4'd8; nr = 4'd14; end
    endcase
    total = 6'(4 * (int'(nk) + 7));
  end

  logic        ram_we;
  logic [4:0]  ram_addr;
  logic [63:0] ram_wdata, ram_rdata;

  aes_ram #(.Width(64), .Depth(30)) u_rk (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic cfg_hit;
  assign cfg.ready = (state_q == StIdle) && !ovalid_q;
  assign cfg_hit = cfg.valid && cfg.ready && (cfg.index <= CfgKeySize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '{default: '0};
      ksize_q <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CfgKey0:    key_q[0] <= cfg.data;
        CfgKey1:    key_q[1] <= cfg.data;
        CfgKey2:    key_q[2] <= cfg.data;
        CfgKey3:    key_q[3] <= cfg.data;
        CfgKeySize: ksize_q <= cfg.data[1:0];
        default:    ;
      endcase
    end
  end

  assign in_ch.ready = (state_q == StIdle) && sched_ok_q && !ovalid_q && !cfg.valid;
  assign out_ch.valid = ovalid_q;
  assign out_ch.result_hi = res_q[127:64];
  assign out_ch.result_lo = res_q[63:0];

  // key expansion step
  logic [31:0] kx_t, kx_new, kx_back;
  always_comb begin
    kx_t = kw_q[31:0];
    if (wmod_q == 3'd0) begin
      kx_t = sub_word({kx_t[23:0], kx_t[31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && wmod_q == 3'd4) begin
      kx_t = sub_word(kx_t);
    end
    kx_back = kw_q[32*(int'(nk)-1) +: 32];
    kx_new = kx_back ^ kx_t;
  end

  // round datapath
  logic [127:0] rk, fwd, inv_s, rnd_out;
  logic         last_rnd;
  always_comb begin
    rk = {khi_q, ram_rdata};
    fwd = '0;
    for (int i = 0; i < 16; i++) begin
      fwd[127-8*i -: 8] = Sbox[st_q[127-8*i -: 8]];
    end
    fwd = shift_rows(fwd, 1'b0);
    inv_s = shift_rows(st_q, 1'b1);
    for (int i = 0; i < 16; i++) begin
      inv_s[127-8*i -: 8] = InvSbox[inv_s[127-8*i -: 8]];
    end
    inv_s = inv_s ^ rk;
    last_rnd = dec_q ? (rnd_q == 4'd0) : (rnd_q == nr);
    rnd_out = '0;
    for (int c = 0; c < 4; c++) begin
      if (dec_q) begin
        rnd_out[127-32*c -: 32] = last_rnd ? inv_s[127-32*c -: 32]
                                           : inv_mix_col(inv_s[127-32*c -: 32]);
      end else begin
        rnd_out[127-32*c -: 32] = (last_rnd ? fwd[127-32*c -: 32]
                                            : mix_col(fwd[127-32*c -: 32]))
                                  ^ rk[127-32*c -: 32];
      end
    end
  end

  always_comb begin
    state_d = state_q; sched_ok_d = sched_ok_q; kw_d = kw_q; wi_d = wi_q;
    wmod_d = wmod_q; rc_d = rc_q; wprev_d = wprev_q; addr_d = addr_q;
    phase_d = phase_q; rnd_d = rnd_q; dec_d = dec_q; st_d = st_q; khi_d = khi_q;
    ovalid_d = ovalid_q; res_d = res_q;
    ram_we = 1'b0; ram_addr = addr_q; ram_wdata = '0;
    if (out_ch.valid && out_ch.ready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (cfg_hit || (!sched_ok_q && !cfg.valid)) begin
          state_d = StCopy; sched_ok_d = 1'b0; wi_d = '0;
        end else if (in_ch.valid && in_ch.ready) begin
          dec_d = in_ch.cmd; st_d = {in_ch.block_hi, in_ch.block_lo};
          rnd_d = in_ch.cmd ? nr : 4'd0;
          addr_d = in_ch.cmd ? 5'({nr, 1'b0}) : 5'd0;
          ram_addr = addr_d;
          phase_d = 1'b0; state_d = StInit;
        end
      end
      StCopy: begin
        // load initial Nk key words, first at bottom of window after shifting
        kw_d = {kw_q[223:0], wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32]};
        if (wi_q[0]) begin
          ram_we = 1'b1; ram_addr = 5'(wi_q[5:1]);
          ram_wdata = {kw_q[31:0], key_q[wi_q[2:1]][31:0]};
        end
        wi_d = wi_q + 6'd1;
        if (wi_q + 6'd1 == 6'(nk)) begin
          state_d = StExpand; wmod_d = '0; rc_d = 8'h01;
        end
      end
      StExpand: begin
        kw_d = {kw_q[223:0], kx_new};
        if (wmod_q == 3'd0) rc_d = xtime(rc_q);
        wmod_d = (wmod_q + 3'd1 == 3'(nk)) ? 3'd0 : wmod_q + 3'd1;
        if (wi_q[0]) begin
          ram_we = 1'b1; ram_addr = 5'(wi_q[5:1]); ram_wdata = {wprev_q, kx_new};
        end else begin
          wprev_d = kx_new;
        end
        wi_d = wi_q + 6'd1;
        if (wi_q + 6'd1 == total) begin
          state_d = StIdle; sched_ok_d = 1'b1;
        end
      end
      StInit: begin
        // phase 0: hi word is on rdata; phase 1: lo word is on rdata
        if (!phase_q) begin
          khi_d = ram_rdata; addr_d = addr_q + 5'd1; ram_addr = addr_d; phase_d = 1'b1;
        end else begin
          st_d = st_q ^ {khi_q, ram_rdata};
          rnd_d = dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
          addr_d = dec_q ? addr_q - 5'd3 : addr_q + 5'd1;
          ram_addr = addr_d; phase_d = 1'b0; state_d = StRound;
        end
      end
      StRound: begin
        if (!phase_q) begin
          khi_d = ram_rdata; addr_d = addr_q + 5'd1; ram_addr = addr_d; phase_d = 1'b1;
        end else begin
          st_d = rnd_out; phase_d = 1'b0;
          if (last_rnd) begin
            state_d = StOut;
          end else begin
            rnd_d = dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
            addr_d = dec_q ? addr_q - 5'd3 : addr_q + 5'd1;
            ram_addr = addr_d;
          end
        end
      end
      StOut: begin
        if (!ovalid_q) begin
          res_d = st_q; ovalid_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; sched_ok_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; sched_ok_q <= sched_ok_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kw_q <= kw_d; wi_q <= wi_d; wmod_q <= wmod_d; rc_q <= rc_d; wprev_q <= wprev_d;
    addr_q <= addr_d; phase_q <= phase_d; rnd_q <= rnd_d; dec_q <= dec_d;
    st_q <= st_d; khi_q <= khi_d; res_q <= res_d;
  end
endmodule

/* rtl/aes_chk.sv */
// Port-level checker for the AES block cipher top, bound to every instance.
// Depends on aes_block_cipher_top_defines.svh and aes_block_cipher_top.
`include "aes_block_cipher_top_defines.svh"
module aes_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic [127:0] out_data
);
  `AES_ASSERT_RST(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid || !rst_ni)
  `AES_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready |=> !in_ready && !cfg_ready)
  `AES_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `AES_ASSERT(a_no_in_while_out, clk_i, rst_ni, out_valid |-> !in_ready)
  `AES_ASSERT(a_no_in_during_cfg, clk_i, rst_ni, cfg_valid |-> !in_ready)
endmodule

bind aes_block_cipher_top aes_chk u_aes_chk (
  .clk_i, .rst_ni,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
  .out_data({out_ch.result_hi, out_ch.result_lo})
);
